// File: sv/pha_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults of the page heap allocator.
package pha_pkg;

  localparam int MAX_PAGES_DEF = 1024;
  localparam int PAGE_BITS_DEF = 12;

  localparam int BASE_W  = 20;
  localparam int COUNT_W = 11;
  localparam int CFG_W   = 20;

  localparam logic [BASE_W-1:0]  BASE_RESET  = '0;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_BADADDR = 3'd3,
    ST_NOTLIVE = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_ADDR,
    SEL_SIZE
  } res_sel_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] block_address;
    logic [31:0] byte_size;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [2:0]  status;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic     clear;
    logic     load;
    logic     start_walk;
    logic     walk;
    logic     save_start;
    logic     mark;
    logic     save_len;
    logic     rel_init;
    logic     release_pg;
    logic     out_load;
    res_sel_t sel;
    status_t  status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       clr_last;
    logic       want_zero;
    logic       want_over;
    logic       bad_addr;
    logic       walk_over;
    logic       at_page;
    logic       map_nz;
    logic       run_hit;
    logic       mark_last;
    logic       rel_last;
    logic [1:0] op;
  } stat_t;

endpackage

// File: sv/pha_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/pha_datapath.sv
`timescale 1ns / 1ps
// Allocator datapath: config registers, page map and size RAMs, walk counters, result register.
module pha_datapath #(
  parameter int MAX_PAGES = pha_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BITS = pha_pkg::PAGE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [pha_pkg::CFG_W-1:0] cfg_data,
  input  pha_pkg::in_word_t        req,
  input  pha_pkg::cmd_t            cmd,
  output pha_pkg::stat_t           sts,
  output pha_pkg::out_word_t       rsp
);

  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int AW = MAX_PAGES > 1 ? $clog2(MAX_PAGES) : 1;
  localparam int PW = CW + 1;
  localparam int WW = 32 - PAGE_BITS;
  localparam logic [31:0] MASK = (32'd1 << PAGE_BITS) - 32'd1;

  logic [pha_pkg::BASE_W-1:0]  base;
  logic [pha_pkg::COUNT_W-1:0] count;
  logic [1:0]  op;
  logic [31:0] addr;
  logic [31:0] size;
  logic [PW-1:0] p;
  logic [CW-1:0] run;
  logic [PW-1:0] start;
  logic [PW-1:0] idx;
  logic [CW-1:0] len;
  logic [CW-1:0] clr;

  logic [31:0]   base_addr;
  logic [31:0]   cnt32;
  logic [31:0]   n32;
  logic [31:0]   rounded;
  logic [WW-1:0] want;
  logic [31:0]   offs;
  logic [WW-1:0] page_full;
  logic [CW-1:0] page;
  logic [CW-1:0] map_q;
  logic [31:0]   size_q;
  logic [PW-1:0] p_next;
  logic [CW-1:0] run_next;
  logic [PW-1:0] start_next;

  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic [CW-1:0] map_wdata;
  logic [AW-1:0] map_raddr;

  assign base_addr = 32'({base, {PAGE_BITS{1'b0}}});
  assign cnt32     = 32'(count);
  assign n32       = cnt32 > 32'(MAX_PAGES) ? 32'(MAX_PAGES) : cnt32;
  assign rounded   = (size + MASK) & ~MASK;
  assign want      = rounded[31:PAGE_BITS];
  assign offs      = addr - base_addr;
  assign page_full = offs[31:PAGE_BITS];
  assign page      = CW'(page_full);

  assign p_next     = (map_q == '0) ? p + PW'(1) : p + PW'(map_q);
  assign run_next   = run + CW'(1);
  assign start_next = p + PW'(1) - PW'(want);

  always_comb begin
    sts.clr_last  = clr == CW'(MAX_PAGES - 1);
    sts.want_zero = want == '0;
    sts.want_over = 32'(want) > n32;
    sts.bad_addr  = ((addr & MASK) != '0) || (addr < base_addr) || (32'(page_full) >= n32);
    sts.walk_over = 32'(p_next) >= n32;
    sts.at_page   = p == PW'(page);
    sts.map_nz    = map_q != '0;
    sts.run_hit   = (map_q == '0) && (run_next == CW'(want));
    sts.mark_last = idx + PW'(1) == start + PW'(want);
    sts.rel_last  = idx + PW'(1) == PW'(page) + PW'(len);
    sts.op        = op;
  end

  assign map_we    = cmd.clear | cmd.mark | cmd.release_pg;
  assign map_waddr = cmd.clear ? clr[AW-1:0] : idx[AW-1:0];
  assign map_wdata = cmd.mark ? CW'(want) : '0;
  assign map_raddr = cmd.start_walk ? '0 : p_next[AW-1:0];

  pha_ram #(.WIDTH(CW), .DEPTH(MAX_PAGES)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  pha_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_sizes (
    .clk   (clk),
    .we    (cmd.mark),
    .waddr (start[AW-1:0]),
    .wdata (size),
    .raddr (page[AW-1:0]),
    .rdata (size_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= pha_pkg::BASE_RESET;
      count <= pha_pkg::COUNT_RESET;
      clr   <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == pha_pkg::CFG_BASE) begin
          base <= cfg_data[pha_pkg::BASE_W-1:0];
        end else begin
          count <= cfg_data[pha_pkg::COUNT_W-1:0];
        end
      end
      if (cmd.clear) begin
        clr <= clr + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= req.op;
      addr <= req.block_address;
      size <= req.byte_size;
    end
    if (cmd.start_walk) begin
      p   <= '0;
      run <= '0;
    end else if (cmd.walk) begin
      p   <= p_next;
      run <= (map_q == '0) ? run_next : '0;
    end
    if (cmd.save_start) begin
      start <= start_next;
    end
    if (cmd.save_len) begin
      len <= map_q;
    end
    priority if (cmd.save_start) begin
      idx <= start_next;
    end else if (cmd.rel_init) begin
      idx <= PW'(page);
    end else if (cmd.mark || cmd.release_pg) begin
      idx <= idx + PW'(1);
    end
    if (cmd.out_load) begin
      rsp.status <= cmd.status;
      unique case (cmd.sel)
        pha_pkg::SEL_ADDR: rsp.result_value <= base_addr + (32'(start) << PAGE_BITS);
        pha_pkg::SEL_SIZE: rsp.result_value <= size_q;
        default:           rsp.result_value <= '0;
      endcase
    end
  end

endmodule

// File: sv/pha_ctrl.sv
`timescale 1ns / 1ps
// Allocator controller: request sequencing state machine and output word handshake.
module pha_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  pha_pkg::stat_t sts,
  output pha_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LIVE,
    S_FIND,
    S_MARK,
    S_FREE,
    S_DONE
  } state_t;

  state_t             state;
  state_t             state_next;
  pha_pkg::status_t   res_status;
  pha_pkg::res_sel_t  res_sel;
  logic               fin;
  pha_pkg::status_t   fin_status;
  pha_pkg::res_sel_t  fin_sel;

  always_comb begin
    cmd        = '0;
    cmd.sel    = res_sel;
    cmd.status = res_status;
    state_next = state;
    fin        = 1'b0;
    fin_status = pha_pkg::ST_OK;
    fin_sel    = pha_pkg::SEL_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op == pha_pkg::OP_ALLOC) begin
          priority if (sts.want_zero) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_ZERO;
          end else if (sts.want_over) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_NOSPACE;
          end else begin
            cmd.start_walk = 1'b1;
            state_next     = S_FIND;
          end
        end else begin
          priority if (sts.bad_addr) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_BADADDR;
          end else if (sts.op == pha_pkg::OP_REALLOC && sts.want_zero) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_ZERO;
          end else begin
            cmd.start_walk = 1'b1;
            state_next     = S_LIVE;
          end
        end
      end
      S_LIVE: begin
        if (sts.at_page) begin
          if (!sts.map_nz) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_NOTLIVE;
          end else begin
            cmd.save_len = 1'b1;
            priority if (sts.op == pha_pkg::OP_FREE) begin
              cmd.rel_init = 1'b1;
              state_next   = S_FREE;
            end else if (sts.op == pha_pkg::OP_QUERY) begin
              fin     = 1'b1;
              fin_sel = pha_pkg::SEL_SIZE;
            end else if (sts.want_over) begin
              fin        = 1'b1;
              fin_status = pha_pkg::ST_NOSPACE;
            end else begin
              cmd.start_walk = 1'b1;
              state_next     = S_FIND;
            end
          end
        end else begin
          cmd.walk = 1'b1;
          if (sts.walk_over) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_NOTLIVE;
          end
        end
      end
      S_FIND: begin
        if (sts.run_hit) begin
          cmd.save_start = 1'b1;
          state_next     = S_MARK;
        end else begin
          cmd.walk = 1'b1;
          if (sts.walk_over) begin
            fin        = 1'b1;
            fin_status = pha_pkg::ST_NOSPACE;
          end
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          if (sts.op == pha_pkg::OP_ALLOC) begin
            fin     = 1'b1;
            fin_sel = pha_pkg::SEL_ADDR;
          end else begin
            cmd.rel_init = 1'b1;
            state_next   = S_FREE;
          end
        end
      end
      S_FREE: begin
        cmd.release_pg = 1'b1;
        if (sts.rel_last) begin
          fin     = 1'b1;
          fin_sel = (sts.op == pha_pkg::OP_FREE) ? pha_pkg::SEL_NONE : pha_pkg::SEL_ADDR;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
    if (fin) begin
      state_next = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      req_stall  <= 1'b1;
      rsp_valid  <= 1'b0;
      res_status <= pha_pkg::ST_OK;
      res_sel    <= pha_pkg::SEL_NONE;
    end else begin
      state     <= state_next;
      req_stall <= state_next != S_IDLE;
      if (fin) begin
        res_status <= fin_status;
        res_sel    <= fin_sel;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/page_heap_allocator.sv
`timescale 1ns / 1ps
// Top level of the first-fit page heap allocator.
// One request at a time; the result word follows the page map walk (one map RAM read
// per page or per block hop) and the marking or clearing of each page in turn; a
// request failed at its first check gives its word without a walk.
// A finished word waits in the output register while the next request is taken.
// After reset (rst, synchronous) the page map is cleared entry by entry with req_stall high.
module page_heap_allocator #(
  parameter int MAX_PAGES = pha_pkg::MAX_PAGES_DEF,
  parameter int PAGE_BITS = pha_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  pha_pkg::in_word_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output pha_pkg::out_word_t        rsp,
  input  logic                      cfg_write,
  input  logic                      cfg_index,
  input  logic [pha_pkg::CFG_W-1:0] cfg_data
);

  pha_pkg::cmd_t  cmd;
  pha_pkg::stat_t sts;

  pha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pha_datapath #(.MAX_PAGES(MAX_PAGES), .PAGE_BITS(PAGE_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

// File: sv/pha_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the page heap allocator, bound to the top level.
module pha_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input pha_pkg::out_word_t rsp
);

  // no output word right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("output word valid after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled output word changed");

  // one request in flight
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pha_pkg::ST_OK |-> rsp.result_value == '0)
    else $error("failed request with nonzero value");

endmodule

bind page_heap_allocator pha_checker u_pha_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
